>>> hw/rtl/iam_pkg.sv
// Package: shared types, codes and constants for the integer ALU.
`timescale 1ns / 1ps
`default_nettype none
package iam_pkg;
  localparam int unsigned DataWidthDef = 64;
  localparam int unsigned FieldW = 64;
  localparam int unsigned CntW = 6;

  typedef enum logic [3:0] {
    FN_MUL = 4'd0, FN_MULHI = 4'd1, FN_DIV = 4'd2, FN_REM = 4'd3,
    FN_ADD = 4'd4, FN_SUB = 4'd5, FN_SHL = 4'd6, FN_SHR = 4'd7,
    FN_AND = 4'd8, FN_XOR = 4'd9, FN_OR = 4'd10
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIVZ = 2'd1, ST_BADOP = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]        func;
    logic [FieldW-1:0] left_operand;
    logic [FieldW-1:0] right_operand;
  } in_beat_t;

  typedef struct packed {
    logic [FieldW-1:0] result_value;
    logic [1:0]        status;
  } out_beat_t;
endpackage
`default_nettype wire

>>> hw/rtl/integer_alu_with_mulhi.sv
// Top level: 64-bit integer ALU with high multiply, built as a chain of cells.
//
//  Channel | Ports                          | Handshake
//  --------+--------------------------------+------------------------------
//  in      | start, busy, in_beat           | taken when start && !busy
//  out     | out_strobe, out_beat           | one-cycle strobe, no stall
//  cfg     | cfg_we, cfg_wdata              | written when cfg_we is high
//
// Every beat walks through DATA_WIDTH cells between one input and one output
// register, and out_strobe is registered together with out_beat.
// Each cell performs one restoring-divide step and adds one multiply row, so
// a new beat enters every cycle while busy is low; busy is high only during
// reset and up to the first edge after reset is released.
// Reset is synchronous on rst_n, clears the valid chain, out_strobe and signed_mode, and sets busy.
// The receiver cannot stall; results leave on the strobe cycle.
`timescale 1ns / 1ps
`default_nettype none
module integer_alu_with_mulhi import iam_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_beat_t  in_beat,
  output logic           out_strobe,
  output out_beat_t      out_beat,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);
  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned SW = W + 18;

  logic signed_mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
    end else if (cfg_we) begin
      signed_mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Stage 0: operand decode and magnitudes.
  logic [W-1:0] a_w, b_w, ma, mb;
  logic         sgn;
  assign a_w = in_beat.left_operand[W-1:0];
  assign b_w = in_beat.right_operand[W-1:0];
  assign sgn = signed_mode_r;
  assign ma  = (sgn && a_w[W-1]) ? (~a_w + 1'b1) : a_w;
  assign mb  = (sgn && b_w[W-1]) ? (~b_w + 1'b1) : b_w;

  logic [W-1:0]  va [0:W];
  logic [W-1:0]  vb [0:W];
  logic [W-1:0]  vr [0:W];
  logic [2*W-1:0] vacc [0:W];
  logic [W-1:0]  vq [0:W];
  logic [W-1:0]  vm [0:W];
  logic [SW-1:0] vs [0:W];
  logic          vv [0:W];

  // Side word: a (W), b low 6, func 4, sgn, na, nb, a sign, b sign, b zero, 2 spare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv[0] <= 1'b0;
    end else begin
      vv[0] <= start && !busy;
    end
    va[0]   <= ma;
    vb[0]   <= mb;
    vr[0]   <= '0;
    vacc[0] <= '0;
    vq[0]   <= '0;
    vm[0]   <= b_w;
    vs[0]   <= {a_w, in_beat.right_operand[CntW-1:0], in_beat.func, sgn,
                sgn && a_w[W-1], sgn && b_w[W-1], a_w[W-1], b_w[W-1],
                (b_w == '0), 2'b00};
  end

  for (genvar i = 0; i < W; i++) begin : g_cell
    iam_cell #(.W(W), .IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .vld_i(vv[i]),
      .a_i(va[i]), .b_i(vb[i]), .rem_i(vr[i]), .acc_i(vacc[i]), .quo_i(vq[i]),
      .mb_i(vm[i]), .side_i(vs[i]),
      .vld_o(vv[i+1]), .a_o(va[i+1]), .b_o(vb[i+1]), .rem_o(vr[i+1]),
      .acc_o(vacc[i+1]), .quo_o(vq[i+1]), .mb_o(vm[i+1]), .side_o(vs[i+1])
    );
  end

  // Final stage: pick the result. Shifts and logic ops use the carried operands.
  logic [SW-1:0] s;
  logic [W-1:0]  a_f, b_f, res, hi, q, r, shl_v, shr_v;
  logic [CntW-1:0] cnt;
  logic [3:0]    fn;
  logic          sg, na, nb, as, bs, bz;
  logic [1:0]    st;
  assign s   = vs[W];
  assign a_f = s[SW-1 -: W];
  assign cnt = s[17:12];
  assign fn  = s[11:8];
  assign sg  = s[7];
  assign na  = s[6];
  assign nb  = s[5];
  assign as  = s[4];
  assign bs  = s[3];
  assign bz  = s[2];
  assign b_f = vm[W];
  assign hi  = vacc[W][2*W-1:W] - ((sg && as) ? b_f : '0) - ((sg && bs) ? a_f : '0);
  assign q   = (na != nb) ? (~vq[W] + 1'b1) : vq[W];
  assign r   = na ? (~vr[W] + 1'b1) : vr[W];
  assign shl_v = ({1'b0, cnt} >= 7'(W)) ? '0 : (a_f << cnt);
  assign shr_v = ({1'b0, cnt} >= 7'(W)) ? ((sg && as) ? '1 : '0)
               : W'($signed({sg && as, a_f}) >>> cnt);

  always_comb begin
    res = '0;
    st  = ST_OK;
    case (fn)
      FN_MUL:   res = vacc[W][W-1:0];
      FN_MULHI: res = hi;
      FN_DIV:   if (bz) st = ST_DIVZ; else res = q;
      FN_REM:   if (bz) st = ST_DIVZ; else res = r;
      FN_ADD:   res = a_f + b_f;
      FN_SUB:   res = a_f - b_f;
      FN_SHL:   res = shl_v;
      FN_SHR:   res = shr_v;
      FN_AND:   res = a_f & b_f;
      FN_XOR:   res = a_f ^ b_f;
      FN_OR:    res = a_f | b_f;
      default:  st  = ST_BADOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= vv[W];
    end
    out_beat.result_value <= FieldW'(res);
    out_beat.status       <= st;
  end
  wire unused_ok = &{1'b0, s[1:0], vb[W], va[W]};
endmodule
`default_nettype wire

>>> hw/rtl/iam_cell.sv
// One cell of the ALU chain: one restoring divide step and one multiply partial-product row.
`timescale 1ns / 1ps
`default_nettype none
module iam_cell import iam_pkg::*; #(
  parameter int unsigned W = DataWidthDef,
  parameter int unsigned IDX = 0
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         vld_i,
  input  wire logic [W-1:0] a_i,      // dividend shift register
  input  wire logic [W-1:0] b_i,      // divisor magnitude
  input  wire logic [W-1:0] rem_i,
  input  wire logic [2*W-1:0] acc_i,  // product accumulator
  input  wire logic [W-1:0] quo_i,
  input  wire logic [W-1:0] mb_i,     // multiplier (unsigned pattern)
  input  wire logic [W+17:0] side_i,  // passthrough control and operands
  output logic              vld_o,
  output logic [W-1:0]      a_o,
  output logic [W-1:0]      b_o,
  output logic [W-1:0]      rem_o,
  output logic [2*W-1:0]    acc_o,
  output logic [W-1:0]      quo_o,
  output logic [W-1:0]      mb_o,
  output logic [W+17:0]     side_o
);
  logic [W:0]     trial;
  logic [W:0]     diff;
  logic           take;
  logic [2*W-1:0] pp;

  // Divide step: bring in the next dividend bit, subtract if it fits.
  assign trial = {rem_i, a_i[W-1]};
  assign diff  = trial - {1'b0, b_i};
  assign take  = !diff[W];
  // Multiply row: add the multiplicand, carried in the top W bits of the side
  // word, times one multiplier bit.
  assign pp = mb_i[IDX] ? ({{W{1'b0}}, side_i[W+17 -: W]} << IDX) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
    a_o    <= {a_i[W-2:0], 1'b0};
    b_o    <= b_i;
    rem_o  <= take ? diff[W-1:0] : trial[W-1:0];
    quo_o  <= {quo_i[W-2:0], take};
    acc_o  <= acc_i + pp;
    mb_o   <= mb_i;
    side_o <= side_i;
  end
endmodule
`default_nettype wire

>>> dv/integer_alu_with_mulhi_tb.sv
// Testbench for the 64-bit integer ALU with high multiply: results are checked beat by beat.
`timescale 1ns / 1ps
`default_nettype none
module integer_alu_with_mulhi_tb;
  import iam_pkg::*;

  localparam int unsigned Width = 64;
  localparam int unsigned Latency = Width + 2;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [Width-1:0] MinVal = {1'b1, {(Width-1){1'b0}}};
  localparam logic [Width-1:0] AllOnes = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_beat_t in_beat = '0;
  logic out_strobe;
  out_beat_t out_beat;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  integer_alu_with_mulhi uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_strobe(out_strobe), .out_beat(out_beat), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Pending operations, and the results we expect back, in order.
  in_beat_t op_queue[$];
  out_beat_t result_queue[$];
  // The testbench's copy of the signed/unsigned mode register.
  logic signed_arith = 1'b0;
  int mismatches = 0;
  int cycles = 0;
  bit driver_quiet = 1'b0;  // Turns off random idling for a stretch.

  // Computes what the ALU should return for one operation under a given mode.
  function automatic out_beat_t alu_predict(in_beat_t op, logic sgn);
    out_beat_t r;
    logic [Width-1:0] a, b, ma, mb, q;
    logic [2*Width-1:0] prod;
    logic [5:0] cnt;
    a = op.left_operand[Width-1:0];
    b = op.right_operand[Width-1:0];
    cnt = op.right_operand[5:0];
    r.result_value = '0;
    r.status = ST_OK;
    case (op.func)
      FN_MUL: r.result_value = a * b;
      FN_MULHI: begin
        if (sgn) prod = $signed({{Width{a[Width-1]}}, a}) * $signed({{Width{b[Width-1]}}, b});
        else prod = {{Width{1'b0}}, a} * {{Width{1'b0}}, b};
        r.result_value = prod[2*Width-1:Width];
      end
      FN_DIV, FN_REM: begin
        if (b == '0) begin
          r.status = ST_DIVZ;
        end else if (!sgn) begin
          r.result_value = (op.func == FN_DIV) ? a / b : a % b;
        end else begin
          // Work on magnitudes; this makes MIN / -1 wrap back to MIN naturally.
          ma = a[Width-1] ? -a : a;
          mb = b[Width-1] ? -b : b;
          if (op.func == FN_DIV) begin
            q = ma / mb;
            r.result_value = (a[Width-1] != b[Width-1]) ? -q : q;
          end else begin
            q = ma % mb;
            r.result_value = a[Width-1] ? -q : q;
          end
        end
      end
      FN_ADD: r.result_value = a + b;
      FN_SUB: r.result_value = a - b;
      FN_SHL: r.result_value = a << cnt;
      FN_SHR: r.result_value = sgn ? $unsigned($signed(a) >>> cnt) : a >> cnt;
      FN_AND: r.result_value = a & b;
      FN_XOR: r.result_value = a ^ b;
      FN_OR: r.result_value = a | b;
      default: r.status = ST_BADOP;
    endcase
    return r;
  endfunction

  // Random operand biased toward the corners that break arithmetic.
  function automatic logic [Width-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return AllOnes;
      2: return MinVal;
      3: return ~MinVal;
      4: return Width'($urandom_range(0, 70));
      5: return -Width'($urandom_range(1, 70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_beat_t make_op(logic [3:0] f, logic [Width-1:0] a, logic [Width-1:0] b);
    in_beat_t op;
    op.func = f;
    op.left_operand = a;
    op.right_operand = b;
    return op;
  endfunction

  // Driver: presents the head of the queue, idling at random. A beat is taken
  // at an edge where start is high and busy is low; the prediction is made then.
  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        result_queue.push_back(alu_predict(in_beat, signed_arith));
        void'(op_queue.pop_front());
      end
      if (op_queue.size() != 0 && (driver_quiet || $urandom_range(0, 99) >= 28)) begin
        start <= 1'b1;
        in_beat <= op_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe beat must match the oldest expected result.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (result_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat %h", out_beat);
      end else begin
        if (out_beat.result_value !== result_queue[0].result_value
            || out_beat.status !== result_queue[0].status) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     result_queue[0].result_value, result_queue[0].status,
                     out_beat.result_value, out_beat.status);
        end
        void'(result_queue.pop_front());
      end
    end
  end

  // Waits until every queued beat is taken and all results are back.
  task automatic drain();
    while (op_queue.size() != 0 || start || result_queue.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  // The mode register is only written while the pipeline is empty.
  task automatic write_mode(logic m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    signed_arith = m;
  endtask

  task automatic queue_directed();
    op_queue.push_back(make_op(FN_MUL, AllOnes, AllOnes));
    op_queue.push_back(make_op(FN_MULHI, AllOnes, AllOnes));
    op_queue.push_back(make_op(FN_MULHI, MinVal, MinVal));
    op_queue.push_back(make_op(FN_DIV, MinVal, AllOnes));
    op_queue.push_back(make_op(FN_REM, MinVal, AllOnes));
    op_queue.push_back(make_op(FN_DIV, 64'd100, '0));
    op_queue.push_back(make_op(FN_REM, AllOnes, '0));
    op_queue.push_back(make_op(FN_DIV, -64'd7, 64'd2));
    op_queue.push_back(make_op(FN_REM, -64'd7, 64'd2));
    op_queue.push_back(make_op(FN_ADD, AllOnes, 64'd1));
    op_queue.push_back(make_op(FN_SUB, '0, 64'd1));
    op_queue.push_back(make_op(FN_SHL, AllOnes, 64'd63));
    op_queue.push_back(make_op(FN_SHL, 64'd1, 64'hFFFF_FFFF_FFFF_FFC1));
    op_queue.push_back(make_op(FN_SHR, MinVal, 64'd63));
    op_queue.push_back(make_op(FN_SHR, AllOnes, 64'd0));
    op_queue.push_back(make_op(FN_AND, AllOnes, 64'h5555_5555_5555_5555));
    op_queue.push_back(make_op(FN_XOR, AllOnes, 64'h5555_5555_5555_5555));
    op_queue.push_back(make_op(FN_OR, '0, 64'hAAAA_AAAA_AAAA_AAAA));
    for (int f = 11; f < 16; f++) op_queue.push_back(make_op(4'(f), AllOnes, AllOnes));
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      op_queue.push_back(make_op(4'($urandom_range(0, 15) < 14 ? $urandom_range(0, 10)
                                                               : $urandom_range(11, 15)),
                                 pick_operand(), pick_operand()));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Unsigned directed, signed directed, signed random, unsigned random, then signed random.
    queue_directed();
    drain();
    write_mode(1'b1);
    queue_directed();
    drain();
    driver_quiet = 1'b1;
    queue_random(300);
    drain();
    driver_quiet = 1'b0;
    write_mode(1'b0);
    queue_random(700);
    drain();
    write_mode(1'b1);
    queue_random(700);
    drain();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
